/* rtl/core/lwkd_pkg.sv */
// ----------------------------------------------------------------------------
// Longest window package
// Widths, reset values and the types that the controller and the datapath of
// the longest k-distinct window unit share.
// ----------------------------------------------------------------------------
package lwkd_pkg;

	// Alphabet and field widths fixed by the interface.
	localparam int ALPHABET    = 128;
	localparam int SYM_W       = 7;
	localparam int BEST_W      = 13;
	localparam int CFG_W       = 8;
	localparam int BUDGET_W    = 9;
	localparam int MAX_LEN_DEF = 4096;

	localparam logic [CFG_W-1:0] MAX_DISTINCT_RST = 8'd2;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FORCE,
		ST_EV_CNT,
		ST_EV_UPD,
		ST_PUSH,
		ST_CHECK
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // take the input word, read the count of its symbol
		logic set_ovf;     // window full on arrival: flag overflow
		logic store_rd;    // read the oldest symbol of the window
		logic cnt_rd_ev;   // read the count of the oldest symbol
		logic evict;       // drop the oldest symbol
		logic cnt_rd_sym;  // read the count of the held symbol
		logic push;        // append the held symbol
		logic result;      // register the result word
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;        // window holds the largest number of symbols
		logic shrink;      // distinct budget is negative and window not empty
		logic out_free;    // output register can take a word
	} status_t;

endpackage

/* rtl/core/lwkd_if.sv */
// ----------------------------------------------------------------------------
// Longest window channel interfaces
// Valid/ready channels for the input symbols, the result words and the
// register write port.
// ----------------------------------------------------------------------------
interface lwkd_in_if import lwkd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

interface lwkd_out_if import lwkd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BEST_W-1:0] best_length;
	logic              final_res;
	logic              overflow;

	modport source (output valid, output best_length, output final_res, output overflow,
		input ready);
	modport sink (input valid, input best_length, input final_res, input overflow,
		output ready);
endinterface

interface lwkd_cfg_if import lwkd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/lwkd_ctrl.sv */
// ----------------------------------------------------------------------------
// Longest window controller
// Sequences the forced eviction of a full window, the push of each symbol and
// the eviction loop that brings the window back within its distinct budget.
// ----------------------------------------------------------------------------
module lwkd_ctrl import lwkd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   forced_q;

	// State and forced-eviction flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			forced_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FORCE) begin
				forced_q <= 1'b1;
			end else if (state_q == ST_EV_UPD) begin
				forced_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = status.full ? ST_FORCE : ST_PUSH;
				end
			end
			ST_FORCE:  state_d = ST_EV_CNT;
			ST_EV_CNT: state_d = ST_EV_UPD;
			ST_EV_UPD: state_d = forced_q ? ST_PUSH : ST_CHECK;
			ST_PUSH:   state_d = ST_CHECK;
			ST_CHECK: begin
				if (status.shrink) begin
					state_d = ST_EV_CNT;
				end else if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Commands.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_FORCE: begin
				cmd.set_ovf  = 1'b1;
				cmd.store_rd = 1'b1;
			end
			ST_EV_CNT: cmd.cnt_rd_ev = 1'b1;
			ST_EV_UPD: begin
				cmd.evict      = 1'b1;
				cmd.cnt_rd_sym = forced_q;
			end
			ST_PUSH:   cmd.push = 1'b1;
			ST_CHECK: begin
				cmd.store_rd = status.shrink;
				cmd.result   = !status.shrink && status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* rtl/core/lwkd_dp.sv */
// ----------------------------------------------------------------------------
// Longest window datapath
// Symbol count memory with validity bits, window store, pointers, distinct
// budget, best length and the output register.
// ----------------------------------------------------------------------------
module lwkd_dp import lwkd_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           status,
	input  logic [SYM_W-1:0]  in_symbol,
	input  logic              in_last,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BEST_W-1:0] out_best_length,
	output logic              out_final_res,
	output logic              out_overflow
);

	localparam int PTR_W = $clog2(MAX_LEN);
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_LEN - 1);
	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_LEN);

	// Memories.
	logic [LEN_W-1:0] cnt_mem [ALPHABET];
	logic [SYM_W-1:0] store_mem [MAX_LEN];

	logic [ALPHABET-1:0] cnt_vld_q;
	logic [LEN_W-1:0]    cnt_rd_q;
	logic                cnt_rd_vld_q;
	logic [SYM_W-1:0]    store_rd_q;

	// Window and string state.
	logic [CFG_W-1:0]           max_distinct_q;
	logic [SYM_W-1:0]           sym_q;
	logic                       last_q;
	logic                       active_q;
	logic [PTR_W-1:0]           head_q;
	logic [PTR_W-1:0]           tail_q;
	logic [LEN_W-1:0]           len_q;
	logic signed [BUDGET_W-1:0] budget_q;
	logic [LEN_W-1:0]           best_q;
	logic                       ovf_q;

	// Output register.
	logic              out_valid_q;
	logic [BEST_W-1:0] out_best_q;
	logic              out_final_q;
	logic              out_ovf_q;

	logic             cnt_rd_en;
	logic [SYM_W-1:0] cnt_raddr;
	logic             cnt_we;
	logic [SYM_W-1:0] cnt_waddr;
	logic [LEN_W-1:0] cnt_wdata;
	logic [LEN_W-1:0] cnt_eff;
	logic             clear;

	// Count as seen by the logic: an entry never written since the string began is zero.
	assign cnt_eff = cnt_rd_vld_q ? cnt_rd_q : '0;
	assign clear   = cmd.result && last_q;

	// Count read address selection.
	always_comb begin
		cnt_rd_en = cmd.accept || cmd.cnt_rd_ev || cmd.cnt_rd_sym;
		priority if (cmd.accept) begin
			cnt_raddr = in_symbol;
		end else if (cmd.cnt_rd_ev) begin
			cnt_raddr = store_rd_q;
		end else begin
			cnt_raddr = sym_q;
		end
	end

	// Count write: decrement on eviction of a counted symbol, increment on push.
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = sym_q;
		cnt_wdata = cnt_eff + 1'b1;
		if (cmd.evict) begin
			cnt_we    = cnt_eff != '0;
			cnt_waddr = store_rd_q;
			cnt_wdata = cnt_eff - 1'b1;
		end else if (cmd.push) begin
			cnt_we = 1'b1;
		end
	end

	// Count memory with write-through on a read of the same entry.
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cnt_rd_en) begin
			if (cnt_we && (cnt_waddr == cnt_raddr)) begin
				cnt_rd_q <= cnt_wdata;
			end else begin
				cnt_rd_q <= cnt_mem[cnt_raddr];
			end
		end
	end

	// Validity of the count entries for the current string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q    <= '0;
			cnt_rd_vld_q <= 1'b0;
		end else begin
			if (cnt_rd_en) begin
				cnt_rd_vld_q <= (cnt_we && (cnt_waddr == cnt_raddr)) || cnt_vld_q[cnt_raddr];
			end
			if (clear) begin
				cnt_vld_q <= '0;
			end else if (cnt_we) begin
				cnt_vld_q[cnt_waddr] <= 1'b1;
			end
		end
	end

	// Window store.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			store_mem[tail_q] <= sym_q;
		end
		if (cmd.store_rd) begin
			store_rd_q <= store_mem[head_q];
		end
	end

	// Input word hold.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sym_q  <= in_symbol;
			last_q <= in_last;
		end
	end

	// Pointers, length, budget, best length and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distinct_q <= MAX_DISTINCT_RST;
			active_q       <= 1'b0;
			head_q         <= '0;
			tail_q         <= '0;
			len_q          <= '0;
			budget_q       <= '0;
			best_q         <= '0;
			ovf_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_distinct_q <= cfg_data;
			end
			if (cmd.accept && !active_q) begin
				active_q <= 1'b1;
				budget_q <= BUDGET_W'(max_distinct_q);
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.evict) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
				len_q  <= len_q - 1'b1;
				if (cnt_eff == LEN_W'(1)) begin
					budget_q <= budget_q + 1'b1;
				end
			end
			if (cmd.push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
				len_q  <= len_q + 1'b1;
				if (cnt_eff == '0) begin
					budget_q <= budget_q - 1'b1;
				end
			end
			if (clear) begin
				active_q <= 1'b0;
				head_q   <= '0;
				tail_q   <= '0;
				len_q    <= '0;
				best_q   <= '0;
				ovf_q    <= 1'b0;
			end else if (cmd.result && (len_q > best_q)) begin
				best_q <= len_q;
			end
		end
	end

	// Output register: loaded with the result word, emptied by the handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result) begin
			out_best_q  <= BEST_W'((len_q > best_q) ? len_q : best_q);
			out_final_q <= last_q;
			out_ovf_q   <= ovf_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_best_length = out_best_q;
	assign out_final_res   = out_final_q;
	assign out_overflow    = out_ovf_q;

	// Status to the controller.
	assign status.full     = len_q == LEN_FULL;
	assign status.shrink   = budget_q[BUDGET_W-1] && (len_q != '0);
	assign status.out_free = !out_valid_q || out_ready;

endmodule

/* rtl/core/longest_window_k_distinct_unit.sv */
// Sequence: a taken word is pushed and checked, and its result word is registered from the
// check state once the output register is free; each symbol evicted to restore the distinct
// budget adds a count read and a count update, and a full window first forces one eviction.
// Throughput: one word at a time; the next is taken in the cycle after the result is
// registered.
// Reset: arst_n clears the window, best length, overflow flag and count validity at once.
// ----------------------------------------------------------------------------
// Longest window with at most k distinct symbols
// Sliding-window unit that reports, for each symbol, the longest window seen
// so far in the string with no more than max_distinct distinct symbols.
// ----------------------------------------------------------------------------
module longest_window_k_distinct_unit import lwkd_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lwkd_in_if.sink    in,
	lwkd_out_if.source out,
	lwkd_cfg_if.sink   cfg
);

	cmd_t    cmd;
	status_t status;

	// The register port is always ready.
	assign cfg.ready = 1'b1;

	// Controller.
	lwkd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath.
	lwkd_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.in_symbol       (in.symbol),
		.in_last         (in.last),
		.cfg_we          (cfg.valid),
		.cfg_data        (cfg.data),
		.out_valid       (out.valid),
		.out_ready       (out.ready),
		.out_best_length (out.best_length),
		.out_final_res   (out.final_res),
		.out_overflow    (out.overflow)
	);

endmodule

/* rtl/core/lwkd_chk.sv */
// ----------------------------------------------------------------------------
// Longest window port checker
// Watches the ports of the longest window unit over time.
// ----------------------------------------------------------------------------
module lwkd_chk import lwkd_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BEST_W-1:0] out_best_length,
	input logic              out_final_res,
	input logic              out_overflow
);

	localparam logic [BEST_W-1:0] BEST_SAT = BEST_W'(MAX_LEN);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_best_length)
			&& $stable(out_final_res) && $stable(out_overflow))
		else $error("result word changed while stalled");

	// One word at a time: the input closes after a word is taken.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// An overflowed window has reached the saturated length.
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_overflow |-> out_best_length == BEST_SAT)
		else $error("overflow reported without a saturated length");

	// A new result word appears only after the input has closed for the item.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result word appeared too early");

endmodule

bind longest_window_k_distinct_unit lwkd_chk #(
	.MAX_LEN (MAX_LEN)
) u_lwkd_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in.valid),
	.in_ready        (in.ready),
	.out_valid       (out.valid),
	.out_ready       (out.ready),
	.out_best_length (out.best_length),
	.out_final_res   (out.final_res),
	.out_overflow    (out.overflow)
);
